// ===== rtl/lbts_pkg.sv =====
`default_nettype none

package lbts_pkg;

   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_READY    = 1'b1;

   localparam logic [1:0] PERR_NONE   = 2'd0;
   localparam logic [1:0] PERR_ACTIVE = 2'd1;
   localparam logic [1:0] PERR_RANGE  = 2'd2;

   localparam logic [1:0] IERR_NONE     = 2'd0;
   localparam logic [1:0] IERR_NONPOS   = 2'd1;
   localparam logic [1:0] IERR_MISMATCH = 2'd2;

   typedef struct packed {
      logic load;
      logic exec;
   } ctl_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/lbts_ctrl.sv =====
`default_nettype none

module lbts_ctrl (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output lbts_pkg::ctl_cmd_type ctl
);
   import lbts_pkg::*;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      ctl.load = 1'b0;
      ctl.exec = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               ctl.load = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (out_free) begin
               ctl.exec = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = ctl.exec ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   a_exec_slot_free: assert property (@(posedge clock) disable iff (reset)
      ctl.exec |-> (!rsp_valid_ff || rsp_ready))
      else $error("result register overwritten while still pending");

   a_load_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken without evaluation step");

   a_valid_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.exec))
      else $error("response raised without evaluation");

endmodule

`default_nettype wire

// ===== rtl/lbts_datapath.sv =====
`default_nettype none

module lbts_datapath #(
   parameter int PARTICIPANTS = 8,
   parameter int CREDIT_BITS  = 8
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire lbts_pkg::ctl_cmd_type ctl,
   input  wire                   req_cmd,
   input  wire signed [7:0]      req_participant,
   input  wire signed [31:0]     req_interval_ns,
   output logic                  rsp_ok,
   output logic [1:0]            rsp_participant_error,
   output logic [1:0]            rsp_interval_error,
   output logic [63:0]           rsp_sim_time_ns
);
   import lbts_pkg::*;

   localparam logic [CREDIT_BITS-1:0] CreditMax = '1;

   logic                    cmd_ff;
   logic [7:0]              part_ff;
   logic [31:0]             ivl_ff;

   logic [PARTICIPANTS-1:0] active_ff, active_in;
   logic [CREDIT_BITS-1:0]  credit_ff [PARTICIPANTS];
   logic [CREDIT_BITS-1:0]  credit_in [PARTICIPANTS];
   logic [CREDIT_BITS-1:0]  bumped    [PARTICIPANTS];
   logic [30:0]             tick_ff, tick_in;
   logic [63:0]             time_ff, time_in;

   logic                    ok_ff, ok_in;
   logic [1:0]              perr_ff, perr_in;
   logic [1:0]              ierr_ff, ierr_in;

   logic                    in_range;
   logic [PARTICIPANTS-1:0] sel;
   logic                    hit_active;
   logic                    pgood, igood;
   logic                    all_credit;

   always_comb begin
      in_range = (part_ff < 8'(PARTICIPANTS));
      for (int i = 0; i < PARTICIPANTS; i++) begin
         sel[i] = in_range && (part_ff == 8'(i));
      end
      hit_active = |(active_ff & sel);

      active_in = active_ff;
      tick_in   = tick_ff;
      time_in   = time_ff;
      for (int i = 0; i < PARTICIPANTS; i++) begin
         credit_in[i] = credit_ff[i];
      end
      ok_in      = 1'b0;
      perr_in    = PERR_NONE;
      ierr_in    = IERR_NONE;
      pgood      = 1'b0;
      igood      = 1'b0;
      all_credit = 1'b1;

      for (int i = 0; i < PARTICIPANTS; i++) begin
         bumped[i] = (sel[i] && (credit_ff[i] != CreditMax)) ?
                     credit_ff[i] + CREDIT_BITS'(1) : credit_ff[i];
         if (active_ff[i] && (bumped[i] == '0)) begin
            all_credit = 1'b0;
         end
      end

      if (cmd_ff == CMD_REGISTER) begin
         if (!in_range) begin
            perr_in = PERR_RANGE;
         end else if (hit_active) begin
            perr_in = PERR_ACTIVE;
         end else begin
            active_in = active_ff | sel;
            pgood     = 1'b1;
         end
         if ((ivl_ff == 32'd0) || ivl_ff[31]) begin
            ierr_in = IERR_NONPOS;
         end else if (tick_ff == 31'd0) begin
            tick_in = ivl_ff[30:0];
            igood   = 1'b1;
         end else if (ivl_ff[30:0] != tick_ff) begin
            ierr_in = IERR_MISMATCH;
         end else begin
            igood = 1'b1;
         end
         ok_in = pgood && igood;
      end else begin
         if (!in_range) begin
            perr_in = PERR_RANGE;
         end
         for (int i = 0; i < PARTICIPANTS; i++) begin
            credit_in[i] = (all_credit && active_ff[i]) ?
                           bumped[i] - CREDIT_BITS'(1) : bumped[i];
         end
         if (all_credit) begin
            time_in = time_ff + {33'd0, tick_ff};
            ok_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff  <= req_cmd;
         part_ff <= $unsigned(req_participant);
         ivl_ff  <= $unsigned(req_interval_ns);
      end
      if (ctl.exec) begin
         ok_ff   <= ok_in;
         perr_ff <= perr_in;
         ierr_ff <= ierr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         tick_ff   <= '0;
         time_ff   <= '0;
         for (int i = 0; i < PARTICIPANTS; i++) begin
            credit_ff[i] <= '0;
         end
      end else if (ctl.exec) begin
         active_ff <= active_in;
         tick_ff   <= tick_in;
         time_ff   <= time_in;
         for (int i = 0; i < PARTICIPANTS; i++) begin
            credit_ff[i] <= credit_in[i];
         end
      end
   end

   assign rsp_ok                = ok_ff;
   assign rsp_participant_error = perr_ff;
   assign rsp_interval_error    = ierr_ff;
   assign rsp_sim_time_ns       = time_ff;

endmodule

`default_nettype wire

// ===== rtl/lockstep_barrier_time_stepper.sv =====
// A request is taken into the request registers in ST_IDLE, evaluated in ST_EXEC
// once the response register is free, and its response registered. No new request
// is taken until then; one response may wait while the next request is taken.
// Reset: synchronous, active high; clears active mask, credits, tick interval,
// simulated time and the response valid flag.
`default_nettype none

module lockstep_barrier_time_stepper #(
   parameter int PARTICIPANTS = 8,
   parameter int CREDIT_BITS  = 8
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_ready,
   input  wire               req_cmd,
   input  wire signed [7:0]  req_participant,
   input  wire signed [31:0] req_interval_ns,
   output logic              rsp_valid,
   input  wire               rsp_ready,
   output logic              rsp_ok,
   output logic [1:0]        rsp_participant_error,
   output logic [1:0]        rsp_interval_error,
   output logic [63:0]       rsp_sim_time_ns
);
   import lbts_pkg::*;

   ctl_cmd_type ctl;

   lbts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   lbts_datapath #(
      .PARTICIPANTS (PARTICIPANTS),
      .CREDIT_BITS  (CREDIT_BITS)
   ) u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .ctl                   (ctl),
      .req_cmd               (req_cmd),
      .req_participant       (req_participant),
      .req_interval_ns       (req_interval_ns),
      .rsp_ok                (rsp_ok),
      .rsp_participant_error (rsp_participant_error),
      .rsp_interval_error    (rsp_interval_error),
      .rsp_sim_time_ns       (rsp_sim_time_ns)
   );

endmodule

`default_nettype wire

// ===== sim/lockstep_barrier_time_stepper_tb.sv =====
`default_nettype none

module lockstep_barrier_time_stepper_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lbts_pkg::*;

   localparam int          PARTS      = 8;
   localparam logic [7:0]  CREDIT_MAX = 8'hFF;
   localparam logic [31:0] TICK_NS    = 32'd1000;
   localparam int          RANDOM_REQUESTS = 1230;

   typedef struct packed {
      logic        ok;
      logic [1:0]  perr;
      logic [1:0]  ierr;
      logic [63:0] time_ns;
   } barrier_outcome_type;

   class barrier_clock_model;
      logic [PARTS-1:0]     active;
      logic [7:0]           credit [PARTS];
      logic [30:0]          tick;
      logic [63:0]          now_ns;
      barrier_outcome_type  pending[$];
      int                   errors;

      function new();
         active = '0;
         foreach (credit[i]) credit[i] = '0;
         tick   = '0;
         now_ns = '0;
         errors = 0;
      endfunction

      function void note_request(logic c, logic [7:0] p, logic [31:0] iv);
         barrier_outcome_type r;
         bit               in_range;
         bit               pgood;
         bit               igood;
         bit               all_ready;
         int               idx;
         r         = '0;
         pgood     = 0;
         igood     = 0;
         all_ready = 1;
         in_range  = (p < PARTS);
         idx       = int'(p);
         if (c == CMD_REGISTER) begin
            if (!in_range) begin
               r.perr = PERR_RANGE;
            end else if (active[idx]) begin
               r.perr = PERR_ACTIVE;
            end else begin
               active[idx] = 1'b1;
               pgood = 1;
            end
            if (iv == 32'd0 || iv[31]) begin
               r.ierr = IERR_NONPOS;
            end else if (tick == '0) begin
               tick  = iv[30:0];
               igood = 1;
            end else if (iv[30:0] != tick) begin
               r.ierr = IERR_MISMATCH;
            end else begin
               igood = 1;
            end
            r.ok = pgood && igood;
         end else begin
            if (!in_range) begin
               r.perr = PERR_RANGE;
            end else if (credit[idx] != CREDIT_MAX) begin
               credit[idx] = credit[idx] + 8'd1;
            end
            for (int i = 0; i < PARTS; i++) begin
               if (active[i] && credit[i] == 8'd0) all_ready = 0;
            end
            if (all_ready) begin
               for (int i = 0; i < PARTS; i++) begin
                  if (active[i]) credit[i] = credit[i] - 8'd1;
               end
               now_ns = now_ns + 64'(tick);
               r.ok   = 1'b1;
            end
         end
         r.time_ns = now_ns;
         pending.push_back(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t %s mismatch: expected %0d actual %0d", $realtime, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic ok, logic [1:0] pe, logic [1:0] ie, logic [63:0] t);
         barrier_outcome_type w;
         if (pending.size() == 0) begin
            $display("%0t unexpected response: expected none actual time %0d", $realtime, t);
            errors++;
            return;
         end
         w = pending.pop_front();
         compare_field("ok", 64'(w.ok), 64'(ok));
         compare_field("participant_error", 64'(w.perr), 64'(pe));
         compare_field("interval_error", 64'(w.ierr), 64'(ie));
         compare_field("sim_time_ns", w.time_ns, t);
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_cmd = CMD_REGISTER;
   logic signed [7:0]  req_participant = '0;
   logic signed [31:0] req_interval_ns = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_ok;
   logic [1:0]         rsp_participant_error;
   logic [1:0]         rsp_interval_error;
   logic [63:0]        rsp_sim_time_ns;

   bit                 gaps_on = 1'b1;
   barrier_clock_model model = new();

   lockstep_barrier_time_stepper u_top (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_cmd               (req_cmd),
      .req_participant       (req_participant),
      .req_interval_ns       (req_interval_ns),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_ok                (rsp_ok),
      .rsp_participant_error (rsp_participant_error),
      .rsp_interval_error    (rsp_interval_error),
      .rsp_sim_time_ns       (rsp_sim_time_ns)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            model.note_request(req_cmd, req_participant, req_interval_ns);
         end
         if (rsp_valid && rsp_ready) begin
            model.check_response(rsp_ok, rsp_participant_error, rsp_interval_error,
                                 rsp_sim_time_ns);
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (gaps_on) begin
         rsp_ready <= ($urandom_range(99) >= 25);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_request(input logic c, input logic signed [7:0] p,
                               input logic signed [31:0] iv);
      while (gaps_on && $urandom_range(99) < 25) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= c;
      req_participant <= p;
      req_interval_ns <= iv;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (model.pending.size() != 0);
   endtask

   task automatic send_random_request();
      int                 kind;
      int                 pick;
      logic signed [7:0]  p;
      logic signed [31:0] iv;
      kind = $urandom_range(99);
      pick = $urandom_range(5);
      p    = 8'($urandom_range(PARTS - 1));
      if (kind >= 70 && kind < 78) p = 8'($urandom_range(255, PARTS));
      if (kind >= 78 && $urandom_range(1) == 1) p = 8'($urandom_range(255, PARTS));
      case (pick)
         0: iv = TICK_NS;
         1: iv = TICK_NS;
         2: iv = 32'($urandom);
         3: iv = {1'b1, 31'($urandom)};
         4: iv = ($urandom_range(1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: iv = '0;
      endcase
      send_request((kind < 78) ? CMD_READY : CMD_REGISTER, p, iv);
   endtask

   initial begin
      #2_000_000;
      $display("lockstep_barrier_time_stepper_tb: errors");
      $finish;
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_request(CMD_READY, 0, 0);
      send_request(CMD_REGISTER, 0, 0);
      send_request(CMD_REGISTER, 1, 32'h8000_0000);
      send_request(CMD_REGISTER, -1, -1);
      send_request(CMD_REGISTER, -128, TICK_NS);
      send_request(CMD_REGISTER, 127, TICK_NS);
      send_request(CMD_REGISTER, 8, 32'h7FFF_FFFF);
      send_request(CMD_REGISTER, 0, TICK_NS);
      send_request(CMD_REGISTER, 2, TICK_NS);
      send_request(CMD_READY, -128, -1);
      send_request(CMD_READY, 127, 32'h7FFF_FFFF);
      send_request(CMD_READY, 5, 0);
      send_request(CMD_READY, 0, 0);
      send_request(CMD_READY, 1, 0);
      send_request(CMD_READY, 2, 0);
      send_request(CMD_REGISTER, 5, TICK_NS);
      send_request(CMD_READY, 0, 0);
      send_request(CMD_READY, 1, 0);
      send_request(CMD_READY, 2, 0);
      send_request(CMD_READY, 2, 0);
      send_request(CMD_REGISTER, 3, TICK_NS + 32'd1);
      wait_drained();

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         gaps_on = !(n >= 500 && n < 750);
         if (n == 900) wait_drained();
         if (n < 280 && $urandom_range(9) != 0) begin
            send_request(CMD_READY, 7, 32'($urandom));
         end else begin
            send_random_request();
         end
      end

      wait_drained();
      repeat (10) @(posedge clock);
      if (model.errors == 0) begin
         $display("lockstep_barrier_time_stepper_tb: clean");
      end else begin
         $display("lockstep_barrier_time_stepper_tb: errors");
      end
      $finish;
   end

endmodule

`default_nettype wire
